// ===== rtl/cpd_pkg.sv =====
// Shared constants, command type and sequencer states for the closest pair block.
package cpd_pkg;

  localparam int unsigned CPD_MAX_POINTS = 64;
  localparam int unsigned CPD_COORD_BITS = 16;
  localparam int unsigned CPD_FRAC_BITS  = 8;
  localparam int unsigned CPD_FIFO_DEPTH = 4;

  // Classification of one accepted point, front to back.
  typedef struct packed {
    logic wr;    // point goes into the store
    logic last;  // point closes the set
    logic ovf;   // a point of this set was dropped, this one included
  } cpd_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DRAIN,
    ST_SQRT,
    ST_DONE
  } cpd_state_e;

endpackage

// ===== rtl/cpd_if.sv =====
// Point and result channel interfaces (valid/ready).
interface cpd_point_if
  import cpd_pkg::*;
#(
  parameter int unsigned COORD_BITS = CPD_COORD_BITS
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic                         last_point;

  modport source (output valid, point_x, point_y, last_point, input ready);
  modport sink   (input valid, point_x, point_y, last_point, output ready);
endinterface

interface cpd_result_if
  import cpd_pkg::*;
#(
  parameter int unsigned SQ_W  = 2 * CPD_COORD_BITS + 1,
  parameter int unsigned FIX_W = CPD_COORD_BITS + 1 + CPD_FRAC_BITS
) ();
  logic             valid;
  logic             ready;
  logic [SQ_W-1:0]  min_sq_distance;
  logic [FIX_W-1:0] min_distance_fixed;
  logic             no_pair;
  logic             store_overflow;

  modport source (output valid, min_sq_distance, min_distance_fixed, no_pair,
                  store_overflow, input ready);
  modport sink   (input valid, min_sq_distance, min_distance_fixed, no_pair,
                  store_overflow, output ready);
endinterface

// ===== rtl/closest_pair_distance.sv =====
// Top level of the closest pair distance block.
//
// Points enter on pt_i, one transfer per point; last_point closes the set.
// The front end takes a point in every cycle while the four-entry command
// queue has room; up to MAX_POINTS points are stored, later ones of the
// same set are dropped and flag store_overflow.
// After the closing point the back end walks all n*(n-1)/2 pairs through
// one distance pipeline fed by a two-read-port point store: one pair per
// cycle, then the pipeline drains and the root unit is loaded, the
// bit-serial square root runs and the result goes into the result
// register; for fewer than two points the search is skipped and the
// result is valid with no_pair set.
// One transfer on res_o carries the result. While it waits for the
// receiver, the back end keeps loading and searching the next set and
// holds that set's result until the register is free; pt_i.ready drops
// once the queue fills. Reset empties the queue and the point count; the
// store itself needs no clearing.
module closest_pair_distance
  import cpd_pkg::*;
#(
  parameter int unsigned MAX_POINTS = CPD_MAX_POINTS,
  parameter int unsigned COORD_BITS = CPD_COORD_BITS
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  cpd_point_if.sink    pt_i,
  cpd_result_if.source res_o
);

  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
  localparam int unsigned CMD_W = $bits(cpd_cmd_t) + 2 * COORD_BITS + CNT_W;

  logic                         push, full, empty, pop;
  cpd_cmd_t                     f_ctrl, b_ctrl;
  logic signed [COORD_BITS-1:0] f_x, f_y, b_x, b_y;
  logic [CNT_W-1:0]             f_addr, b_addr;
  logic [CMD_W-1:0]             q_din, q_dout;
  logic                         b_ready;

  cpd_front #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pt_i       (pt_i),
    .full_i     (full),
    .push_o     (push),
    .cmd_ctrl_o (f_ctrl),
    .cmd_x_o    (f_x),
    .cmd_y_o    (f_y),
    .cmd_addr_o (f_addr)
  );

  assign q_din = {f_ctrl, f_x, f_y, f_addr};

  cpd_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CPD_FIFO_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .din_i   (q_din),
    .full_o  (full),
    .pop_i   (pop),
    .dout_o  (q_dout),
    .empty_o (empty)
  );

  assign {b_ctrl, b_x, b_y, b_addr} = q_dout;
  assign pop = b_ready && !empty;

  cpd_back #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!empty),
    .cmd_ready_o (b_ready),
    .cmd_ctrl_i  (b_ctrl),
    .cmd_x_i     (b_x),
    .cmd_y_i     (b_y),
    .cmd_addr_i  (b_addr),
    .res_o       (res_o)
  );

endmodule

// ===== rtl/cpd_front.sv =====
// Front end: takes points, counts the set and decides store or drop.
module cpd_front
  import cpd_pkg::*;
#(
  parameter int unsigned MAX_POINTS = CPD_MAX_POINTS,
  parameter int unsigned COORD_BITS = CPD_COORD_BITS,
  localparam int unsigned CNT_W     = $clog2(MAX_POINTS + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  cpd_point_if.sink                    pt_i,
  input  logic                         full_i,
  output logic                         push_o,
  output cpd_cmd_t                     cmd_ctrl_o,
  output logic signed [COORD_BITS-1:0] cmd_x_o,
  output logic signed [COORD_BITS-1:0] cmd_y_o,
  output logic [CNT_W-1:0]             cmd_addr_o
);

  logic [CNT_W-1:0] count_q, count_d;
  logic             ovf_q, ovf_d;
  logic             room;
  logic             accept;

  assign pt_i.ready = !full_i;
  assign accept     = pt_i.valid && pt_i.ready;
  assign room       = count_q < CNT_W'(MAX_POINTS);

  assign push_o          = accept;
  assign cmd_ctrl_o.wr   = room;
  assign cmd_ctrl_o.last = pt_i.last_point;
  assign cmd_ctrl_o.ovf  = ovf_q || !room;
  assign cmd_x_o         = pt_i.point_x;
  assign cmd_y_o         = pt_i.point_y;
  assign cmd_addr_o      = count_q;

  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    if (accept) begin
      if (pt_i.last_point) begin
        count_d = '0;
        ovf_d   = 1'b0;
      end else if (room) begin
        count_d = count_q + CNT_W'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_POINTS))
    else $error("point count beyond store size");

endmodule

// ===== rtl/cpd_fifo.sv =====
// Small command queue between front and back end.
module cpd_fifo
  import cpd_pkg::*;
#(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = CPD_FIFO_DEPTH,
  localparam int unsigned PTR_W = $clog2(DEPTH),
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] din_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] dout_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] buf_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == CNT_W'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign dout_o  = buf_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wr_q] <= din_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      cnt_q <= cnt_q + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("queue fill beyond depth");

endmodule

// ===== rtl/cpd_back.sv =====
// Back end: point store, all-pairs distance pipeline, square root, result register.
module cpd_back
  import cpd_pkg::*;
#(
  parameter int unsigned MAX_POINTS = CPD_MAX_POINTS,
  parameter int unsigned COORD_BITS = CPD_COORD_BITS,
  localparam int unsigned CNT_W     = $clog2(MAX_POINTS + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cmd_valid_i,
  output logic                         cmd_ready_o,
  input  cpd_cmd_t                     cmd_ctrl_i,
  input  logic signed [COORD_BITS-1:0] cmd_x_i,
  input  logic signed [COORD_BITS-1:0] cmd_y_i,
  input  logic [CNT_W-1:0]             cmd_addr_i,
  cpd_result_if.source                 res_o
);

  localparam int unsigned IDX_W = $clog2(MAX_POINTS);
  localparam int unsigned C     = COORD_BITS;
  localparam int unsigned SQ_W  = 2 * C + 1;
  localparam int unsigned FIX_W = C + 1 + CPD_FRAC_BITS;
  localparam int unsigned RAD_W = 2 * FIX_W;
  localparam int unsigned SC_W  = $clog2(FIX_W + 1);

  cpd_state_e state_q, state_d;

  logic [2*C-1:0]   mem [MAX_POINTS];
  logic [2*C-1:0]   rd_a_q, rd_b_q;
  logic [CNT_W-1:0] i_q, j_q, n_q, n_new;
  logic             v1_q, v2_q, v3_q;
  logic [C-1:0]     dx_q, dy_q;
  logic [2*C-1:0]   sqx_q, sqy_q;
  logic [SQ_W-1:0]  best_q, sum;
  logic             ovf_q, nopair_q;
  logic [RAD_W-1:0] rad_q;
  logic [FIX_W-1:0] rem_q;
  logic [FIX_W-1:0] root_q;
  logic [SC_W-1:0]  sc_q;
  logic [FIX_W+1:0] rem_sh, trial;
  logic signed [C:0] diff_x, diff_y;
  logic             pop, issue, last_pair, pipe_busy, sq_last, out_free, res_valid_q;

  assign cmd_ready_o = state_q == ST_IDLE;
  assign pop         = cmd_valid_i && cmd_ready_o;
  assign n_new       = cmd_addr_i + CNT_W'(cmd_ctrl_i.wr);
  assign issue       = state_q == ST_SEARCH;
  assign last_pair   = (j_q == n_q - CNT_W'(1)) && (i_q == n_q - CNT_W'(2));
  assign pipe_busy   = v1_q || v2_q || v3_q;
  assign sq_last     = sc_q == SC_W'(FIX_W - 1);
  assign out_free    = !res_valid_q || res_o.ready;

  // distance datapath
  assign diff_x = $signed({rd_a_q[2*C-1], rd_a_q[2*C-1:C]})
                - $signed({rd_b_q[2*C-1], rd_b_q[2*C-1:C]});
  assign diff_y = $signed({rd_a_q[C-1], rd_a_q[C-1:0]})
                - $signed({rd_b_q[C-1], rd_b_q[C-1:0]});
  assign sum    = {1'b0, sqx_q} + {1'b0, sqy_q};

  // one digit of the square root per cycle; the remainder stays below
  // 2^FIX_W until the final digit, whose remainder is not used
  assign rem_sh = {rem_q, rad_q[RAD_W-1 -: 2]};
  assign trial  = {root_q, 2'b01};

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (pop && cmd_ctrl_i.last) begin
          state_d = (n_new >= CNT_W'(2)) ? ST_SEARCH : ST_DONE;
        end
      end
      ST_SEARCH: if (last_pair) state_d = ST_DRAIN;
      ST_DRAIN:  if (!pipe_busy) state_d = ST_SQRT;
      ST_SQRT:   if (sq_last) state_d = ST_DONE;
      ST_DONE:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      v1_q    <= issue;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      if (state_q == ST_DONE && out_free) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // point store
  always_ff @(posedge clk_i) begin
    if (pop && cmd_ctrl_i.wr) begin
      mem[cmd_addr_i[IDX_W-1:0]] <= {cmd_x_i, cmd_y_i};
    end
  end

  always_ff @(posedge clk_i) begin
    rd_a_q <= mem[i_q[IDX_W-1:0]];
    rd_b_q <= mem[j_q[IDX_W-1:0]];
  end

  // pair walk, distance stages, running minimum, square root
  always_ff @(posedge clk_i) begin
    if (pop && cmd_ctrl_i.last) begin
      n_q      <= n_new;
      ovf_q    <= cmd_ctrl_i.ovf;
      nopair_q <= n_new < CNT_W'(2);
      i_q      <= '0;
      j_q      <= CNT_W'(1);
      best_q   <= '1;
    end
    if (issue) begin
      if (j_q == n_q - CNT_W'(1)) begin
        i_q <= i_q + CNT_W'(1);
        j_q <= i_q + CNT_W'(2);
      end else begin
        j_q <= j_q + CNT_W'(1);
      end
    end
    dx_q  <= diff_x[C] ? C'(-diff_x) : diff_x[C-1:0];
    dy_q  <= diff_y[C] ? C'(-diff_y) : diff_y[C-1:0];
    sqx_q <= dx_q * dx_q;
    sqy_q <= dy_q * dy_q;
    if (v3_q && sum < best_q) begin
      best_q <= sum;
    end
    if (state_q == ST_DRAIN && !pipe_busy) begin
      rad_q  <= {1'b0, best_q, {(2 * CPD_FRAC_BITS){1'b0}}};
      rem_q  <= '0;
      root_q <= '0;
      sc_q   <= '0;
    end
    if (state_q == ST_SQRT) begin
      rad_q <= {rad_q[RAD_W-3:0], 2'b00};
      sc_q  <= sc_q + SC_W'(1);
      if (rem_sh >= trial) begin
        rem_q  <= FIX_W'(rem_sh - trial);
        root_q <= {root_q[FIX_W-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh[FIX_W-1:0];
        root_q <= {root_q[FIX_W-2:0], 1'b0};
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_free) begin
      res_o.min_sq_distance    <= nopair_q ? '0 : best_q;
      res_o.min_distance_fixed <= nopair_q ? '0 : root_q;
      res_o.no_pair            <= nopair_q;
      res_o.store_overflow     <= ovf_q;
    end
  end

  assign res_o.valid = res_valid_q;

  a_sqrt_idle_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SQRT |-> !pipe_busy)
    else $error("distance pipeline busy during square root");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SEARCH |-> (i_q < j_q) && (j_q < n_q))
    else $error("pair indices out of order");

  a_nopair_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_o.no_pair |->
      (res_o.min_sq_distance == '0) && (res_o.min_distance_fixed == '0))
    else $error("no-pair result carries a distance");

endmodule

// ===== sim/tb_closest_pair_distance.sv =====
// Self-checking testbench for the closest pair distance block.
module tb_closest_pair_distance;
  import cpd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW         = CPD_COORD_BITS;
  localparam int SQ_W       = 2 * CPD_COORD_BITS + 1;
  localparam int FIX_W      = CPD_COORD_BITS + 1 + CPD_FRAC_BITS;
  localparam int NUM_ITEMS  = 1250;
  // A full 64-point search walks all 2016 pairs, then drains and runs the square root.
  localparam int SEARCH_LAT = 2100;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic                 last;
  } point_t;

  typedef struct packed {
    logic [SQ_W-1:0]  sq;
    logic [FIX_W-1:0] fix;
    logic             no_pair;
    logic             ovf;
  } dist_result_t;

  logic clk_i;
  logic rst_ni;

  cpd_point_if  pt_if ();
  cpd_result_if res_if ();

  closest_pair_distance i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pt_i   (pt_if),
    .res_o  (res_if)
  );

  // Points waiting to be sent, and results the predictor expects.
  point_t       point_queue[$];
  dist_result_t expected_results[$];

  // Predictor copy of the point store for the set being loaded.
  logic signed [CW-1:0] set_x [CPD_MAX_POINTS];
  logic signed [CW-1:0] set_y [CPD_MAX_POINTS];
  int unsigned          set_count;
  logic                 set_dropped;

  int   errors;
  int   items_queued;
  int   points_sent;
  int   results_seen;
  int   overflow_results;
  int   no_pair_results;
  int   zero_dist_results;
  int   cycles;
  logic pt_fire;

  // Sender burst state and receiver stall state.
  int burst_left;
  int gap_left;
  int rx_mode;
  int rx_mode_left;
  int rx_stall_left;

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Floor of sqrt(d) with 8 fraction bits, found one result bit at a time.
  function automatic logic [FIX_W-1:0] fixed_sqrt(longint unsigned d);
    longint unsigned v;
    longint unsigned r;
    longint unsigned t;
    int              b;
    v = d << (2 * CPD_FRAC_BITS);
    r = 0;
    for (b = FIX_W - 1; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r[FIX_W-1:0];
  endfunction

  // Minimum squared distance over every stored pair of the current set.
  function automatic dist_result_t closest_result();
    dist_result_t    r;
    longint unsigned best;
    longint unsigned d;
    longint          dx;
    longint          dy;
    bit              found;
    int unsigned     i;
    int unsigned     j;
    found = 1'b0;
    best  = 0;
    for (i = 0; i < set_count; i++) begin
      for (j = i + 1; j < set_count; j++) begin
        dx = longint'(set_x[i]) - longint'(set_x[j]);
        dy = longint'(set_y[i]) - longint'(set_y[j]);
        d  = longint'(dx * dx + dy * dy);
        if (!found || d < best) begin
          best  = d;
          found = 1'b1;
        end
      end
    end
    r.no_pair = !found;
    r.sq      = found ? best[SQ_W-1:0] : '0;
    r.fix     = found ? fixed_sqrt(best) : '0;
    r.ovf     = set_dropped;
    return r;
  endfunction

  task automatic push_point(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                            logic last);
    point_t p;
    p.x    = x;
    p.y    = y;
    p.last = last;
    point_queue.push_back(p);
    items_queued++;
  endtask

  // mode 0: anywhere, mode 1: cluster around base, mode 2: corner values
  function automatic logic signed [CW-1:0] rand_coord(int mode, int base, int spread);
    int          v;
    logic [31:0] r;
    r = $urandom();
    case (mode)
      0: v = int'(r[CW-1:0]);
      1: v = base + int'($urandom_range(0, spread)) - spread / 2;
      default: begin
        case ($urandom_range(0, 4))
          0: v = -32768;
          1: v = 32767;
          2: v = 0;
          3: v = -1;
          default: v = 1;
        endcase
      end
    endcase
    return v[CW-1:0];
  endfunction

  task automatic add_random_set(int n);
    int mode;
    int base;
    int spread;
    int k;
    mode   = ($urandom_range(0, 9) < 5) ? 1 : ($urandom_range(0, 3) == 0 ? 2 : 0);
    base   = int'($urandom_range(0, 65535)) - 32768;
    spread = (1 << $urandom_range(0, 12)) - 1;
    for (k = 0; k < n; k++) begin
      push_point(rand_coord(mode, base, spread), rand_coord(mode, base, spread),
                 k == n - 1);
    end
  endtask

  task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // Sender: bursts of random length, some followed by a random gap. A presented
  // point is held until its transfer completes.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      pt_if.valid <= 1'b0;
    end else if (!(pt_if.valid && !pt_fire)) begin
      if (gap_left > 0) begin
        gap_left--;
        pt_if.valid <= 1'b0;
      end else if (point_queue.size() == 0) begin
        pt_if.valid <= 1'b0;
      end else begin
        point_t p;
        p = point_queue.pop_front();
        pt_if.point_x    <= p.x;
        pt_if.point_y    <= p.y;
        pt_if.last_point <= p.last;
        pt_if.valid      <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 32);
          // Most bursts run back to back; some are followed by a gap.
          gap_left   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
        end else begin
          burst_left--;
        end
      end
    end
  end

  // Receiver: stall pattern switches between always ready, light and heavy
  // random backpressure, and long stall runs.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = $urandom_range(0, 3);
        rx_mode_left = $urandom_range(50, 400);
      end else begin
        rx_mode_left--;
      end
      case (rx_mode)
        0: res_if.ready <= 1'b1;
        1: res_if.ready <= ($urandom_range(0, 3) != 0);
        2: res_if.ready <= ($urandom_range(0, 3) == 0);
        default: begin
          if (rx_stall_left > 0) begin
            rx_stall_left--;
            res_if.ready <= 1'b0;
          end else begin
            if ($urandom_range(0, 19) == 0) rx_stall_left = $urandom_range(5, 60);
            res_if.ready <= 1'b1;
          end
        end
      endcase
    end
  end

  // Monitor and predictor: results are checked against the oldest
  // expectation, accepted points update the predictor store.
  always @(posedge clk_i) begin
    dist_result_t got;
    dist_result_t want;
    pt_fire <= rst_ni && pt_if.valid && pt_if.ready;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got.sq      = res_if.min_sq_distance;
      got.fix     = res_if.min_distance_fixed;
      got.no_pair = res_if.no_pair;
      got.ovf     = res_if.store_overflow;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, sq %0d fix %0d no_pair %0b overflow %0b",
                 $time, got.sq, got.fix, got.no_pair, got.ovf);
        errors++;
      end else begin
        want = expected_results.pop_front();
        check_field("min_sq_distance", want.sq, got.sq);
        check_field("min_distance_fixed", want.fix, got.fix);
        check_field("no_pair", want.no_pair, got.no_pair);
        check_field("store_overflow", want.ovf, got.ovf);
        results_seen++;
        if (want.ovf) overflow_results++;
        if (want.no_pair) no_pair_results++;
        if (!want.no_pair && want.sq == 0) zero_dist_results++;
      end
    end
    if (rst_ni && pt_if.valid && pt_if.ready) begin
      points_sent++;
      // Points past the store capacity are dropped, the closing one too.
      if (set_count < CPD_MAX_POINTS) begin
        set_x[set_count] = pt_if.point_x;
        set_y[set_count] = pt_if.point_y;
        set_count++;
      end else begin
        set_dropped = 1'b1;
      end
      if (pt_if.last_point) begin
        expected_results.push_back(closest_result());
        set_count   = 0;
        set_dropped = 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still expected", $time,
               expected_results.size());
      $display("tb_closest_pair_distance failed");
      $finish;
    end
  end

  initial begin
    int n;
    int pick;
    rst_ni            = 1'b0;
    pt_if.valid       = 1'b0;
    pt_if.point_x     = '0;
    pt_if.point_y     = '0;
    pt_if.last_point  = 1'b0;
    res_if.ready      = 1'b0;
    pt_fire           = 1'b0;
    set_count         = 0;
    set_dropped       = 1'b0;
    errors            = 0;
    items_queued      = 0;
    points_sent       = 0;
    results_seen      = 0;
    overflow_results  = 0;
    no_pair_results   = 0;
    zero_dist_results = 0;
    cycles            = 0;
    burst_left        = 1;
    gap_left          = 0;
    rx_mode           = 0;
    rx_mode_left      = 0;
    rx_stall_left     = 0;

    // Directed sets: lone point, coincident pair, extreme corners,
    // fractional and exact roots, alternating bit patterns.
    push_point(16'sd0, 16'sd0, 1'b1);
    push_point(16'sd5, -16'sd7, 1'b0);
    push_point(16'sd5, -16'sd7, 1'b1);
    push_point(-16'sd32768, -16'sd32768, 1'b0);
    push_point(16'sd32767, 16'sd32767, 1'b1);
    push_point(16'sd32767, -16'sd32768, 1'b0);
    push_point(-16'sd32768, 16'sd32767, 1'b0);
    push_point(16'sd0, 16'sd0, 1'b1);
    push_point(16'sd1, 16'sd0, 1'b0);
    push_point(16'sd0, 16'sd1, 1'b0);
    push_point(-16'sd1, -16'sd1, 1'b0);
    push_point(16'sd100, 16'sd100, 1'b1);
    push_point(16'sd3, 16'sd4, 1'b0);
    push_point(16'sd0, 16'sd0, 1'b0);
    push_point(16'sd21845, -16'sd21846, 1'b1);
    push_point(16'sd0, 16'sd0, 1'b0);
    push_point(16'sd1, 16'sd1, 1'b1);
    push_point(-16'sd21846, 16'sd21845, 1'b1);

    // Random sets: one overflowing set and one exactly full set up front,
    // then mostly small sets with a few large and overflowing ones.
    add_random_set(CPD_MAX_POINTS + 6);
    add_random_set(CPD_MAX_POINTS);
    while (items_queued < NUM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) n = $urandom_range(1, 6);
      else if (pick < 85) n = $urandom_range(7, 20);
      else if (pick < 95) n = $urandom_range(21, CPD_MAX_POINTS);
      else n = $urandom_range(CPD_MAX_POINTS + 1, CPD_MAX_POINTS + 8);
      add_random_set(n);
    end

    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    while (point_queue.size() != 0 || pt_if.valid || expected_results.size() != 0)
      @(negedge clk_i);
    repeat (SEARCH_LAT) @(negedge clk_i);

    $display("Sent %0d points; checked %0d results (%0d overflow, %0d no pair, %0d zero).",
             points_sent, results_seen, overflow_results, no_pair_results,
             zero_dist_results);
    if (errors == 0) begin
      $display("tb_closest_pair_distance passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("tb_closest_pair_distance failed");
    end
    $finish;
  end

endmodule

// ===== closest_pair_distance.f =====
rtl/cpd_pkg.sv
rtl/cpd_if.sv
rtl/cpd_front.sv
rtl/cpd_fifo.sv
rtl/cpd_back.sv
rtl/closest_pair_distance.sv
sim/tb_closest_pair_distance.sv
